/* rtl/sas_pkg.sv */
// ----------------------------------------------------------------------------
// sas_pkg
// Shared types, codes and the microcode ROM of the sprite animation sequencer.
// ----------------------------------------------------------------------------
package sas_pkg;

    localparam int OP_W    = 3;
    localparam int PARAM_W = 16;
    localparam int INSTR_W = OP_W + PARAM_W;
    localparam int IP_W    = 16;

    localparam logic [OP_W-1:0] OP_END   = 3'd0;
    localparam logic [OP_W-1:0] OP_FRAME = 3'd1;
    localparam logic [OP_W-1:0] OP_GOTO  = 3'd2;
    localparam logic [OP_W-1:0] OP_LOOP  = 3'd3;
    localparam logic [OP_W-1:0] OP_SLEEP = 3'd4;

    localparam logic [2:0] KIND_WR_INSTR = 3'd0;
    localparam logic [2:0] KIND_WR_START = 3'd1;
    localparam logic [2:0] KIND_TICK     = 3'd2;
    localparam logic [2:0] KIND_SELECT   = 3'd3;
    localparam logic [2:0] KIND_RESTART  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CODE_ERR = 2'd1;
    localparam logic [1:0] ST_BAD_ANIM = 2'd2;
    localparam logic [1:0] ST_STEP_LIM = 2'd3;

    localparam logic [1:0] CFG_PROG_LEN  = 2'd0;
    localparam logic [1:0] CFG_FRAME_CNT = 2'd1;
    localparam logic [1:0] CFG_ANIM_CNT  = 2'd2;

    localparam logic [PARAM_W-1:0] LOOP_FOREVER = 16'hffff;

    typedef logic [3:0] t_uaddr;

    localparam t_uaddr UA_IDLE   = 4'd0;
    localparam t_uaddr UA_DISP   = 4'd1;
    localparam t_uaddr UA_WRI    = 4'd2;
    localparam t_uaddr UA_WRS    = 4'd3;
    localparam t_uaddr UA_SEL    = 4'd4;
    localparam t_uaddr UA_RST    = 4'd5;
    localparam t_uaddr UA_TICK   = 4'd6;
    localparam t_uaddr UA_HEAD   = 4'd7;
    localparam t_uaddr UA_EXEC   = 4'd8;
    localparam t_uaddr UA_RDEND  = 4'd9;
    localparam t_uaddr UA_REPORT = 4'd10;
    localparam t_uaddr UA_DONE   = 4'd11;

    typedef enum logic [3:0] {
        ACT_NOP      = 4'd0,
        ACT_ACCEPT   = 4'd1,
        ACT_WR_PROG  = 4'd2,
        ACT_WR_START = 4'd3,
        ACT_SELECT   = 4'd4,
        ACT_RESTART  = 4'd5,
        ACT_TICK     = 4'd6,
        ACT_HEAD     = 4'd7,
        ACT_EXEC     = 4'd8,
        ACT_REPORT   = 4'd9
    } t_act;

    typedef enum logic [2:0] {
        COND_NEVER     = 3'd0,
        COND_ALWAYS    = 3'd1,
        COND_NO_ITEM   = 3'd2,
        COND_KIND      = 3'd3,
        COND_TICK_DONE = 3'd4,
        COND_HALT      = 3'd5,
        COND_RUN       = 3'd6,
        COND_OUT_BUSY  = 3'd7
    } t_cond;

    typedef struct packed {
        t_act   act;
        t_cond  cond;
        t_uaddr tgt;
    } t_uword;

    typedef struct packed {
        logic       in_valid;
        logic [2:0] kind;
        logic       tick_done;
        logic       halt;
        logic       run;
        logic       out_busy;
    } t_flags;

    // jump to tgt when cond holds, else fall through; COND_KIND dispatches on the kind
    function automatic t_uword ucode_rom(input t_uaddr a);
        t_uword w;
        unique case (a)
            UA_IDLE:   w = '{act: ACT_ACCEPT,   cond: COND_NO_ITEM,   tgt: UA_IDLE};
            UA_DISP:   w = '{act: ACT_NOP,      cond: COND_KIND,      tgt: UA_RDEND};
            UA_WRI:    w = '{act: ACT_WR_PROG,  cond: COND_ALWAYS,    tgt: UA_RDEND};
            UA_WRS:    w = '{act: ACT_WR_START, cond: COND_ALWAYS,    tgt: UA_RDEND};
            UA_SEL:    w = '{act: ACT_SELECT,   cond: COND_ALWAYS,    tgt: UA_RDEND};
            UA_RST:    w = '{act: ACT_RESTART,  cond: COND_ALWAYS,    tgt: UA_RDEND};
            UA_TICK:   w = '{act: ACT_TICK,     cond: COND_TICK_DONE, tgt: UA_RDEND};
            UA_HEAD:   w = '{act: ACT_HEAD,     cond: COND_HALT,      tgt: UA_RDEND};
            UA_EXEC:   w = '{act: ACT_EXEC,     cond: COND_RUN,       tgt: UA_HEAD};
            UA_RDEND:  w = '{act: ACT_NOP,      cond: COND_NEVER,     tgt: UA_IDLE};
            UA_REPORT: w = '{act: ACT_REPORT,   cond: COND_OUT_BUSY,  tgt: UA_REPORT};
            UA_DONE:   w = '{act: ACT_NOP,      cond: COND_ALWAYS,    tgt: UA_IDLE};
            default:   w = '{act: ACT_NOP,      cond: COND_ALWAYS,    tgt: UA_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* rtl/sas_ram.sv */
// ----------------------------------------------------------------------------
// sas_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sas_useq.sv */
// ----------------------------------------------------------------------------
// sas_useq
// Micro-sequencer: step counter, control ROM and jump logic.
// ----------------------------------------------------------------------------
module sas_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sas_pkg::t_flags i_flags,
    output sas_pkg::t_uword o_uw
);

    sas_pkg::t_uaddr r_upc;
    sas_pkg::t_uaddr n_upc;
    sas_pkg::t_uaddr w_inc;
    sas_pkg::t_uaddr w_disp;
    sas_pkg::t_uword w_uw;

    assign w_uw  = sas_pkg::ucode_rom(r_upc);
    assign w_inc = r_upc + 4'd1;

    always_comb begin
        unique case (i_flags.kind)
            sas_pkg::KIND_WR_INSTR: w_disp = sas_pkg::UA_WRI;
            sas_pkg::KIND_WR_START: w_disp = sas_pkg::UA_WRS;
            sas_pkg::KIND_TICK:     w_disp = sas_pkg::UA_TICK;
            sas_pkg::KIND_SELECT:   w_disp = sas_pkg::UA_SEL;
            sas_pkg::KIND_RESTART:  w_disp = sas_pkg::UA_RST;
            default:                w_disp = w_uw.tgt;
        endcase
    end

    always_comb begin
        unique case (w_uw.cond)
            sas_pkg::COND_NEVER:     n_upc = w_inc;
            sas_pkg::COND_ALWAYS:    n_upc = w_uw.tgt;
            sas_pkg::COND_NO_ITEM:   n_upc = i_flags.in_valid ? w_inc : w_uw.tgt;
            sas_pkg::COND_KIND:      n_upc = w_disp;
            sas_pkg::COND_TICK_DONE: n_upc = i_flags.tick_done ? w_uw.tgt : w_inc;
            sas_pkg::COND_HALT:      n_upc = i_flags.halt ? w_uw.tgt : w_inc;
            sas_pkg::COND_RUN:       n_upc = i_flags.run ? w_uw.tgt : w_inc;
            sas_pkg::COND_OUT_BUSY:  n_upc = i_flags.out_busy ? w_uw.tgt : w_inc;
            default:                 n_upc = sas_pkg::UA_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= sas_pkg::UA_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_uw = w_uw;

endmodule

/* rtl/sas_dpath.sv */
// ----------------------------------------------------------------------------
// sas_dpath
// Datapath: player state, config registers, stores and the result register.
// ----------------------------------------------------------------------------
module sas_dpath #(
    parameter int PROG_DEPTH = 256,
    parameter int ANIM_DEPTH = 16,
    parameter int MAX_STEPS  = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sas_pkg::t_uword     i_uw,
    output sas_pkg::t_flags     o_flags,
    input  logic                i_in_valid,
    input  logic [2:0]          i_kind,
    input  logic [7:0]          i_address,
    input  logic [2:0]          i_instr_opcode,
    input  logic [15:0]         i_instr_param,
    input  logic [3:0]          i_anim_index,
    input  logic [15:0]         i_elapsed,
    input  logic                i_cfg_valid,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic signed [16:0]  o_frame_index,
    output logic                o_ended,
    output logic [1:0]          o_status,
    output logic signed [4:0]   o_current_anim
);

    localparam int PAW = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
    localparam int AAW = (ANIM_DEPTH > 1) ? $clog2(ANIM_DEPTH) : 1;
    localparam int SW  = $clog2(MAX_STEPS + 1);
    localparam logic [16:0]   PDEPTH = 17'(PROG_DEPTH);
    localparam logic [8:0]    ADEPTH = 9'(ANIM_DEPTH);
    localparam logic [SW-1:0] MSTEPS = SW'(MAX_STEPS);

    // config
    logic [8:0]  r_prog_len;
    logic [15:0] r_frame_cnt;
    logic [4:0]  r_anim_cnt;

    // latched item
    logic [2:0]  r_kind,   n_kind;
    logic [7:0]  r_address, n_address;
    logic [2:0]  r_opcode, n_opcode;
    logic [15:0] r_param,  n_param;
    logic [3:0]  r_aidx,   n_aidx;

    // player state
    logic [sas_pkg::IP_W-1:0] r_ip, n_ip;
    logic [15:0]              r_loop, n_loop;
    logic [15:0]              r_pend, n_pend;
    logic signed [16:0]       r_shown, n_shown;
    logic signed [4:0]        r_sel, n_sel;

    // tick working registers
    logic [15:0]   r_elap, n_elap;
    logic [SW-1:0] r_steps, n_steps;
    logic [1:0]    r_status, n_status;

    // result register
    logic               r_out_valid, n_out_valid;
    logic signed [16:0] r_o_frame, n_o_frame;
    logic               r_o_ended, n_o_ended;
    logic [1:0]         r_o_status, n_o_status;
    logic signed [4:0]  r_o_anim, n_o_anim;

    logic [16:0] w_len;
    logic [8:0]  w_anims;
    logic        w_lib;
    logic        w_ip_in;
    logic        w_step_lim;
    logic        w_sel_bad;
    logic        w_out_busy;
    logic        w_run;
    logic        w_ended;
    logic        w_pwe;
    logic        w_swe;
    logic [16:0] w_addr_ext;
    logic [8:0]  w_aidx_ext;
    logic [sas_pkg::INSTR_W-1:0] w_prd;
    logic [sas_pkg::OP_W-1:0]    w_op;
    logic [sas_pkg::PARAM_W-1:0] w_par;
    logic [7:0]                  w_srd;

    assign w_addr_ext = {9'd0, r_address};
    assign w_aidx_ext = {5'd0, r_aidx};

    sas_ram #(
        .WIDTH (sas_pkg::INSTR_W),
        .DEPTH (PROG_DEPTH)
    ) u_prog (
        .i_clk   (i_clk),
        .i_we    (w_pwe),
        .i_waddr (w_addr_ext[PAW-1:0]),
        .i_wdata ({r_opcode, r_param}),
        .i_raddr (r_ip[PAW-1:0]),
        .o_rdata (w_prd)
    );

    sas_ram #(
        .WIDTH (8),
        .DEPTH (ANIM_DEPTH)
    ) u_start (
        .i_clk   (i_clk),
        .i_we    (w_swe),
        .i_waddr (w_aidx_ext[AAW-1:0]),
        .i_wdata (r_address),
        .i_raddr (w_aidx_ext[AAW-1:0]),
        .o_rdata (w_srd)
    );

    assign w_op  = w_prd[sas_pkg::INSTR_W-1:sas_pkg::PARAM_W];
    assign w_par = w_prd[sas_pkg::PARAM_W-1:0];

    assign w_len      = ({8'd0, r_prog_len} < PDEPTH) ? {8'd0, r_prog_len} : PDEPTH;
    assign w_anims    = ({4'd0, r_anim_cnt} < ADEPTH) ? {4'd0, r_anim_cnt} : ADEPTH;
    assign w_lib      = (w_len != 17'd0);
    assign w_ip_in    = ({1'b0, r_ip} < w_len);
    assign w_step_lim = (r_steps >= MSTEPS);
    assign w_sel_bad  = !w_lib || (w_aidx_ext >= w_anims);
    assign w_out_busy = r_out_valid && i_out_stall;
    assign w_ended    = !w_lib || (w_ip_in && (w_op == sas_pkg::OP_END));

    always_comb begin
        case (w_op)
            sas_pkg::OP_FRAME: w_run = (w_par < r_frame_cnt);
            sas_pkg::OP_GOTO:  w_run = 1'b1;
            sas_pkg::OP_LOOP:  w_run = 1'b1;
            sas_pkg::OP_SLEEP: w_run = (w_par <= r_elap);
            default:           w_run = 1'b0;
        endcase
    end

    assign o_flags = '{
        in_valid:  i_in_valid,
        kind:      r_kind,
        tick_done: !w_lib || (r_pend >= r_elap),
        halt:      (r_elap == 16'd0) || w_step_lim || !w_ip_in,
        run:       w_run,
        out_busy:  w_out_busy
    };

    always_comb begin
        n_kind      = r_kind;
        n_address   = r_address;
        n_opcode    = r_opcode;
        n_param     = r_param;
        n_aidx      = r_aidx;
        n_ip        = r_ip;
        n_loop      = r_loop;
        n_pend      = r_pend;
        n_shown     = r_shown;
        n_sel       = r_sel;
        n_elap      = r_elap;
        n_steps     = r_steps;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_o_frame   = r_o_frame;
        n_o_ended   = r_o_ended;
        n_o_status  = r_o_status;
        n_o_anim    = r_o_anim;
        w_pwe       = 1'b0;
        w_swe       = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (i_uw.act)
            sas_pkg::ACT_ACCEPT: begin
                if (i_in_valid) begin
                    n_kind    = i_kind;
                    n_address = i_address;
                    n_opcode  = i_instr_opcode;
                    n_param   = i_instr_param;
                    n_aidx    = i_anim_index;
                    n_elap    = i_elapsed;
                    n_status  = sas_pkg::ST_OK;
                end
            end
            sas_pkg::ACT_WR_PROG: begin
                w_pwe = (w_addr_ext < PDEPTH);
            end
            sas_pkg::ACT_WR_START: begin
                w_swe = (w_aidx_ext < ADEPTH);
            end
            sas_pkg::ACT_SELECT: begin
                if (w_sel_bad) begin
                    n_status = sas_pkg::ST_BAD_ANIM;
                end else begin
                    n_ip  = {8'd0, w_srd};
                    n_sel = {1'b0, r_aidx};
                end
            end
            sas_pkg::ACT_RESTART: begin
                n_ip    = '0;
                n_loop  = 16'd0;
                n_pend  = 16'd0;
                n_shown = -17'sd1;
            end
            sas_pkg::ACT_TICK: begin
                n_steps = '0;
                if (w_lib) begin
                    if (r_pend >= r_elap) begin
                        n_pend = r_pend - r_elap;
                    end else begin
                        n_elap = r_elap - r_pend;
                        n_pend = 16'd0;
                    end
                end
            end
            sas_pkg::ACT_HEAD: begin
                if (r_elap != 16'd0) begin
                    if (w_step_lim) begin
                        n_status = sas_pkg::ST_STEP_LIM;
                    end else if (!w_ip_in) begin
                        n_status = sas_pkg::ST_CODE_ERR;
                    end
                end
            end
            sas_pkg::ACT_EXEC: begin
                n_steps = r_steps + SW'(1);
                case (w_op)
                    sas_pkg::OP_END: begin
                    end
                    sas_pkg::OP_FRAME: begin
                        if (w_run) begin
                            n_shown = {1'b0, w_par};
                            n_ip    = r_ip + 16'd1;
                        end else begin
                            n_status = sas_pkg::ST_CODE_ERR;
                        end
                    end
                    sas_pkg::OP_GOTO: begin
                        if (r_loop != 16'd0) begin
                            n_ip = w_par;
                            if (r_loop != sas_pkg::LOOP_FOREVER) begin
                                n_loop = r_loop - 16'd1;
                            end
                        end else begin
                            n_ip = r_ip + 16'd1;
                        end
                    end
                    sas_pkg::OP_LOOP: begin
                        n_loop = w_par;
                        n_ip   = r_ip + 16'd1;
                    end
                    sas_pkg::OP_SLEEP: begin
                        n_ip = r_ip + 16'd1;
                        if (w_run) begin
                            n_elap = r_elap - w_par;
                        end else begin
                            n_pend = w_par - r_elap;
                        end
                    end
                    default: begin
                        n_status = sas_pkg::ST_CODE_ERR;
                    end
                endcase
            end
            sas_pkg::ACT_REPORT: begin
                if (!w_out_busy) begin
                    n_out_valid = 1'b1;
                    n_o_frame   = r_shown;
                    n_o_ended   = w_ended;
                    n_o_status  = r_status;
                    n_o_anim    = r_sel;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_len  <= 9'd0;
            r_frame_cnt <= 16'd0;
            r_anim_cnt  <= 5'd0;
            r_ip        <= '0;
            r_loop      <= 16'd0;
            r_pend      <= 16'd0;
            r_shown     <= -17'sd1;
            r_sel       <= -5'sd1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    sas_pkg::CFG_PROG_LEN:  r_prog_len  <= i_cfg_data[8:0];
                    sas_pkg::CFG_FRAME_CNT: r_frame_cnt <= i_cfg_data;
                    sas_pkg::CFG_ANIM_CNT:  r_anim_cnt  <= i_cfg_data[4:0];
                    default: begin
                    end
                endcase
            end
            r_ip        <= n_ip;
            r_loop      <= n_loop;
            r_pend      <= n_pend;
            r_shown     <= n_shown;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_address  <= n_address;
        r_opcode   <= n_opcode;
        r_param    <= n_param;
        r_aidx     <= n_aidx;
        r_elap     <= n_elap;
        r_steps    <= n_steps;
        r_status   <= n_status;
        r_o_frame  <= n_o_frame;
        r_o_ended  <= n_o_ended;
        r_o_status <= n_o_status;
        r_o_anim   <= n_o_anim;
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_index  = r_o_frame;
    assign o_ended        = r_o_ended;
    assign o_status       = r_o_status;
    assign o_current_anim = r_o_anim;

endmodule

/* rtl/sprite_animation_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// sprite_animation_sequencer_unit
// Each item is accepted at the idle step, dispatched on its kind, acted on
// and reported; a tick runs a fetch check and an execute step for each
// instruction, at most MAX_STEPS of them, and may stop at the fetch check.
// One item at a time: the microcode loop (fetch and execute over the single
// instruction store read port) runs each item to its report; the next item
// is accepted only after the result of the last one is loaded.
// Reset: synchronous; player state, config and the result valid clear at once.
// ----------------------------------------------------------------------------
module sprite_animation_sequencer_unit #(
    parameter int PROG_DEPTH = 256,
    parameter int ANIM_DEPTH = 16,
    parameter int MAX_STEPS  = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_kind,
    input  logic [7:0]         i_address,
    input  logic [2:0]         i_instr_opcode,
    input  logic [15:0]        i_instr_param,
    input  logic [3:0]         i_anim_index,
    input  logic [15:0]        i_elapsed,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [16:0] o_frame_index,
    output logic               o_ended,
    output logic [1:0]         o_status,
    output logic signed [4:0]  o_current_anim
);

    sas_pkg::t_uword w_uw;
    sas_pkg::t_flags w_flags;

    sas_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_uw    (w_uw)
    );

    sas_dpath #(
        .PROG_DEPTH (PROG_DEPTH),
        .ANIM_DEPTH (ANIM_DEPTH),
        .MAX_STEPS  (MAX_STEPS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_uw           (w_uw),
        .o_flags        (w_flags),
        .i_in_valid     (i_in_valid),
        .i_kind         (i_kind),
        .i_address      (i_address),
        .i_instr_opcode (i_instr_opcode),
        .i_instr_param  (i_instr_param),
        .i_anim_index   (i_anim_index),
        .i_elapsed      (i_elapsed),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_frame_index  (o_frame_index),
        .o_ended        (o_ended),
        .o_status       (o_status),
        .o_current_anim (o_current_anim)
    );

    assign o_in_stall  = (w_uw.act != sas_pkg::ACT_ACCEPT);
    assign o_cfg_ready = 1'b1;

    a_out_from_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_uw.act == sas_pkg::ACT_REPORT))
        else $error("result valid without a report step");

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (w_uw.cond == sas_pkg::COND_KIND))
        else $error("accepted item not dispatched");

    a_report_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_uw.act == sas_pkg::ACT_REPORT && o_out_valid && i_out_stall)
        |=> (w_uw.act == sas_pkg::ACT_REPORT))
        else $error("report step left while result register full");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sprite_animation_sequencer_unit. A queue of command
// items feeds a falling-edge driver; a rising-edge monitor keeps a cycle-free
// model of the player, predicts the reply for every accepted item and checks
// the replies in order. The instruction store and start table are loaded in
// full first, then a directed pass, then random phases over several register
// settings with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

    localparam int STORE_DEPTH = 256;
    localparam int TABLE_DEPTH = 16;
    localparam int STEP_BUDGET = 64;

    // kinds and opcodes that the block leaves undefined
    localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;
    localparam logic [2:0] OP_UNUSED_FIRST   = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST    = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  address;
        logic [2:0]  opcode;
        logic [15:0] param;
        logic [3:0]  anim;
        logic [15:0] elapsed;
    } t_anim_cmd;

    typedef struct packed {
        logic signed [16:0] frame;
        logic               ended;
        logic [1:0]         status;
        logic signed [4:0]  anim;
    } t_player_view;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [2:0]         i_kind = '0;
    logic [7:0]         i_address = '0;
    logic [2:0]         i_instr_opcode = '0;
    logic [15:0]        i_instr_param = '0;
    logic [3:0]         i_anim_index = '0;
    logic [15:0]        i_elapsed = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [16:0] o_frame_index;
    logic               o_ended;
    logic [1:0]         o_status;
    logic signed [4:0]  o_current_anim;

    sprite_animation_sequencer_unit #(
        .PROG_DEPTH(STORE_DEPTH),
        .ANIM_DEPTH(TABLE_DEPTH),
        .MAX_STEPS (STEP_BUDGET)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_address     (i_address),
        .i_instr_opcode(i_instr_opcode),
        .i_instr_param (i_instr_param),
        .i_anim_index  (i_anim_index),
        .i_elapsed     (i_elapsed),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_frame_index (o_frame_index),
        .o_ended       (o_ended),
        .o_status      (o_status),
        .o_current_anim(o_current_anim)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // player model state
    logic [sas_pkg::INSTR_W-1:0] prog_mem [STORE_DEPTH];
    logic [7:0]                  start_mem [TABLE_DEPTH];
    int unsigned                 play_ip = 0;
    logic [15:0]                 loop_left = '0;
    int unsigned                 sleep_left = 0;
    int                          frame_shown = -1;
    int                          anim_sel = -1;
    int unsigned                 len_reg = 0;
    int unsigned                 frames_reg = 0;
    int unsigned                 anims_reg = 0;

    t_anim_cmd    pending_cmds[$];
    t_player_view expected_views[$];
    t_anim_cmd    cur_cmd;
    bit           cmd_taken = 1'b0;
    int           idle_pct = 0;
    int           stall_pct = 0;
    int           posted = 0;
    int           fault_count = 0;

    function automatic int unsigned live_len();
        return (len_reg < STORE_DEPTH) ? len_reg : STORE_DEPTH;
    endfunction

    function automatic int unsigned live_anims();
        return (anims_reg < TABLE_DEPTH) ? anims_reg : TABLE_DEPTH;
    endfunction

    function automatic logic [1:0] spend_time(input int unsigned elapsed);
        int unsigned                 left;
        int unsigned                 steps;
        int unsigned                 len;
        logic [sas_pkg::OP_W-1:0]    op;
        logic [sas_pkg::PARAM_W-1:0] arg;
        left  = elapsed;
        steps = 0;
        len   = live_len();
        if (len == 0) return sas_pkg::ST_OK;
        if (sleep_left >= left) begin
            sleep_left -= left;
            return sas_pkg::ST_OK;
        end
        left -= sleep_left;
        sleep_left = 0;
        while (left != 0) begin
            if (steps >= STEP_BUDGET) return sas_pkg::ST_STEP_LIM;
            if (play_ip >= len) return sas_pkg::ST_CODE_ERR;
            {op, arg} = prog_mem[play_ip];
            steps++;
            case (op)
                sas_pkg::OP_END: return sas_pkg::ST_OK;
                sas_pkg::OP_FRAME: begin
                    if (arg >= frames_reg) return sas_pkg::ST_CODE_ERR;
                    frame_shown = arg;
                    play_ip++;
                end
                sas_pkg::OP_GOTO: begin
                    if (loop_left != 0) begin
                        play_ip = arg;
                        if (loop_left != sas_pkg::LOOP_FOREVER) loop_left--;
                    end else begin
                        play_ip++;
                    end
                end
                sas_pkg::OP_LOOP: begin
                    loop_left = arg;
                    play_ip++;
                end
                sas_pkg::OP_SLEEP: begin
                    play_ip++;
                    if (arg > left) begin
                        sleep_left = arg - left;
                        return sas_pkg::ST_OK;
                    end
                    left -= arg;
                end
                default: return sas_pkg::ST_CODE_ERR;
            endcase
        end
        return sas_pkg::ST_OK;
    endfunction

    function automatic t_player_view play_cmd(input t_anim_cmd c);
        t_player_view v;
        v.status = sas_pkg::ST_OK;
        case (c.kind)
            sas_pkg::KIND_WR_INSTR: prog_mem[c.address] = {c.opcode, c.param};
            sas_pkg::KIND_WR_START: start_mem[c.anim] = c.address;
            sas_pkg::KIND_TICK:     v.status = spend_time(c.elapsed);
            sas_pkg::KIND_SELECT: begin
                if (live_len() != 0 && c.anim < live_anims()) begin
                    play_ip  = start_mem[c.anim];
                    anim_sel = c.anim;
                end else begin
                    v.status = sas_pkg::ST_BAD_ANIM;
                end
            end
            sas_pkg::KIND_RESTART: begin
                play_ip     = 0;
                loop_left   = '0;
                sleep_left  = 0;
                frame_shown = -1;
            end
            default: ;
        endcase
        if (live_len() == 0)
            v.ended = 1'b1;
        else if (play_ip < live_len())
            v.ended = (prog_mem[play_ip][sas_pkg::INSTR_W-1:sas_pkg::PARAM_W]
                       == sas_pkg::OP_END);
        else
            v.ended = 1'b0;
        v.frame = 17'(frame_shown);
        v.anim  = 5'(anim_sel);
        return v;
    endfunction

    // fields that the kind does not use carry random noise
    task automatic post(input int k, input int a, input int op, input int p, input int an,
                        input int el);
        t_anim_cmd c;
        c.kind    = 3'(k);
        c.address = 8'($urandom);
        c.opcode  = 3'($urandom);
        c.param   = 16'($urandom);
        c.anim    = 4'($urandom);
        c.elapsed = 16'($urandom);
        case (c.kind)
            sas_pkg::KIND_WR_INSTR: begin
                c.address = 8'(a);
                c.opcode  = 3'(op);
                c.param   = 16'(p);
            end
            sas_pkg::KIND_WR_START: begin
                c.address = 8'(a);
                c.anim    = 4'(an);
            end
            sas_pkg::KIND_TICK:   c.elapsed = 16'(el);
            sas_pkg::KIND_SELECT: c.anim = 4'(an);
            default: ;
        endcase
        pending_cmds.push_back(c);
        posted++;
    endtask

    function automatic logic [sas_pkg::INSTR_W-1:0] gen_word(input int a);
        int                          roll;
        logic [sas_pkg::OP_W-1:0]    op;
        logic [sas_pkg::PARAM_W-1:0] arg;
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            op  = sas_pkg::OP_FRAME;
            arg = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 63));
        end else if (roll < 55) begin
            op  = sas_pkg::OP_SLEEP;
            arg = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        end else if (roll < 67) begin
            op  = sas_pkg::OP_LOOP;
            arg = ($urandom_range(0, 9) == 0) ? sas_pkg::LOOP_FOREVER
                                              : 16'($urandom_range(0, 4));
        end else if (roll < 84) begin
            op  = sas_pkg::OP_GOTO;
            arg = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                              : 16'($urandom_range((a > 6) ? a - 6 : 0, a));
        end else if (roll < 95) begin
            op  = sas_pkg::OP_END;
            arg = 16'($urandom);
        end else begin
            op  = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
            arg = 16'($urandom);
        end
        return {op, arg};
    endfunction

    // small counted loop with a frame pair, bound to an animation and played
    task automatic queue_burst();
        int b;
        int k;
        b = (live_len() > 6) ? $urandom_range(0, live_len() - 6) : 0;
        k = (live_anims() != 0 && $urandom_range(0, 9) != 0) ?
            $urandom_range(0, live_anims() - 1) : $urandom_range(0, 15);
        post(sas_pkg::KIND_WR_INSTR, b,     sas_pkg::OP_LOOP,  $urandom_range(1, 3), 0, 0);
        post(sas_pkg::KIND_WR_INSTR, b + 1, sas_pkg::OP_FRAME, $urandom_range(0, 63), 0, 0);
        post(sas_pkg::KIND_WR_INSTR, b + 2, sas_pkg::OP_SLEEP, $urandom_range(1, 30), 0, 0);
        post(sas_pkg::KIND_WR_INSTR, b + 3, sas_pkg::OP_GOTO,  b + 1, 0, 0);
        post(sas_pkg::KIND_WR_INSTR, b + 4, sas_pkg::OP_FRAME, $urandom_range(0, 63), 0, 0);
        post(sas_pkg::KIND_WR_INSTR, b + 5, sas_pkg::OP_END,   $urandom, 0, 0);
        post(sas_pkg::KIND_WR_START, b, 0, 0, k, 0);
        post(sas_pkg::KIND_SELECT, 0, 0, 0, k, 0);
        repeat ($urandom_range(2, 6))
            post(sas_pkg::KIND_TICK, 0, 0, 0, 0, $urandom_range(1, 50));
    endtask

    task automatic queue_random(input int n);
        int                          target;
        int                          r;
        int                          a;
        int                          el;
        logic [sas_pkg::INSTR_W-1:0] w;
        target = posted + n;
        while (posted < target) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                queue_burst();
            end else if (r < 42) begin
                r  = $urandom_range(0, 19);
                el = (r == 0) ? 0 : (r == 1) ? 65535 :
                     (r < 4) ? $urandom_range(0, 65535) : $urandom_range(0, 60);
                post(sas_pkg::KIND_TICK, 0, 0, 0, 0, el);
            end else if (r < 60) begin
                a = (live_len() != 0 && $urandom_range(0, 4) != 0) ?
                    $urandom_range(0, live_len() - 1) : $urandom_range(0, 255);
                w = gen_word(a);
                post(sas_pkg::KIND_WR_INSTR, a, w[sas_pkg::INSTR_W-1:sas_pkg::PARAM_W],
                     w[sas_pkg::PARAM_W-1:0], 0, 0);
            end else if (r < 67) begin
                a = (live_len() != 0 && $urandom_range(0, 3) != 0) ?
                    $urandom_range(0, live_len() - 1) : $urandom_range(0, 255);
                post(sas_pkg::KIND_WR_START, a, 0, 0, $urandom_range(0, 15), 0);
            end else if (r < 80) begin
                post(sas_pkg::KIND_SELECT, 0, 0, 0, $urandom_range(0, 15), 0);
            end else if (r < 87) begin
                post(sas_pkg::KIND_RESTART, 0, 0, 0, 0, 0);
            end else if (r < 92) begin
                post($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST), 0, 0, 0, 0, 0);
            end else begin
                post(sas_pkg::KIND_TICK, 0, 0, 0, 0, $urandom_range(0, 65535));
            end
        end
    endtask

    task automatic drain();
        while (pending_cmds.size() != 0 || i_in_valid || expected_views.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= 16'(val);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            sas_pkg::CFG_PROG_LEN:  len_reg = val & 'h1ff;
            sas_pkg::CFG_FRAME_CNT: frames_reg = val & 'hffff;
            sas_pkg::CFG_ANIM_CNT:  anims_reg = val & 'h1f;
            default: ;
        endcase
    endtask

    task automatic reconfigure(input int len, input int frames, input int anims);
        drain();
        write_reg(sas_pkg::CFG_PROG_LEN, len);
        write_reg(sas_pkg::CFG_FRAME_CNT, frames);
        write_reg(sas_pkg::CFG_ANIM_CNT, anims);
    endtask

    task automatic flag(input string what, input longint want, input longint got);
        if (fault_count < 10)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        fault_count++;
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || cmd_taken) begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                cur_cmd = pending_cmds.pop_front();
                i_in_valid     <= 1'b1;
                i_kind         <= cur_cmd.kind;
                i_address      <= cur_cmd.address;
                i_instr_opcode <= cur_cmd.opcode;
                i_instr_param  <= cur_cmd.param;
                i_anim_index   <= cur_cmd.anim;
                i_elapsed      <= cur_cmd.elapsed;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin : check_views
        t_player_view got;
        t_player_view want;
        cmd_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (cmd_taken) expected_views.push_back(play_cmd(cur_cmd));
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.frame  = o_frame_index;
            got.ended  = o_ended;
            got.status = o_status;
            got.anim   = o_current_anim;
            if (expected_views.size() == 0) begin
                if (fault_count < 10) $display("result item with none pending");
                fault_count++;
            end else begin
                want = expected_views.pop_front();
                if (got.frame !== want.frame) flag("frame_index", want.frame, got.frame);
                if (got.ended !== want.ended) flag("ended", want.ended, got.ended);
                if (got.status !== want.status) flag("status", want.status, got.status);
                if (got.anim !== want.anim) flag("current_anim", want.anim, got.anim);
            end
        end
    end

    initial begin
        logic [sas_pkg::INSTR_W-1:0] w;
        int                          len;
        int                          frames;
        int                          anims;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // load every entry so no fetch ever hits an unwritten one
        idle_pct  = 28;
        stall_pct = 28;
        for (int a = 0; a < STORE_DEPTH; a++) begin
            case (a)
                0:       w = {sas_pkg::OP_LOOP, 16'd1};
                1:       w = {sas_pkg::OP_FRAME, 16'd63};
                2:       w = {sas_pkg::OP_SLEEP, 16'd100};
                3:       w = {sas_pkg::OP_GOTO, 16'd1};
                4:       w = {sas_pkg::OP_FRAME, 16'd64};
                5:       w = {sas_pkg::OP_END, 16'd0};
                6:       w = {sas_pkg::OP_LOOP, sas_pkg::LOOP_FOREVER};
                7:       w = {sas_pkg::OP_GOTO, 16'd7};
                8:       w = {OP_UNUSED_LAST, 16'hffff};
                9:       w = {sas_pkg::OP_LOOP, 16'd1};
                10:      w = {sas_pkg::OP_GOTO, 16'd300};
                11:      w = {sas_pkg::OP_SLEEP, 16'd0};
                12:      w = {sas_pkg::OP_END, 16'hffff};
                default: w = gen_word(a);
            endcase
            post(sas_pkg::KIND_WR_INSTR, a, w[sas_pkg::INSTR_W-1:sas_pkg::PARAM_W],
                 w[sas_pkg::PARAM_W-1:0], 0, 0);
        end
        post(sas_pkg::KIND_WR_START, 0, 0, 0, 0, 0);
        post(sas_pkg::KIND_WR_START, 6, 0, 0, 1, 0);
        post(sas_pkg::KIND_WR_START, 8, 0, 0, 2, 0);
        post(sas_pkg::KIND_WR_START, 9, 0, 0, 3, 0);
        post(sas_pkg::KIND_WR_START, 11, 0, 0, 4, 0);
        for (int k = 5; k < TABLE_DEPTH; k++)
            post(sas_pkg::KIND_WR_START, $urandom_range(0, 40), 0, 0, k, 0);

        // no library loaded yet
        post(sas_pkg::KIND_TICK, 0, 0, 0, 0, 5);
        post(sas_pkg::KIND_SELECT, 0, 0, 0, 0, 0);
        for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++) post(k, 0, 0, 0, 0, 0);
        post(sas_pkg::KIND_RESTART, 0, 0, 0, 0, 0);

        reconfigure(16, 64, 5);
        idle_pct  = 0;
        stall_pct = 0;
        post(sas_pkg::KIND_TICK, 0, 0, 0, 0, 0);
        post(sas_pkg::KIND_TICK, 0, 0, 0, 0, 1);
        post(sas_pkg::KIND_TICK, 0, 0, 0, 0, 99);
        post(sas_pkg::KIND_TICK, 0, 0, 0, 0, 1);
        post(sas_pkg::KIND_TICK, 0, 0, 0, 0, 65535);
        post(sas_pkg::KIND_TICK, 0, 0, 0, 0, 5);
        post(sas_pkg::KIND_SELECT, 0, 0, 0, 5, 0);
        post(sas_pkg::KIND_SELECT, 0, 0, 0, 1, 0);
        post(sas_pkg::KIND_TICK, 0, 0, 0, 0, 65535);
        post(sas_pkg::KIND_SELECT, 0, 0, 0, 2, 0);
        post(sas_pkg::KIND_TICK, 0, 0, 0, 0, 1);
        post(sas_pkg::KIND_SELECT, 0, 0, 0, 3, 0);
        post(sas_pkg::KIND_TICK, 0, 0, 0, 0, 3);
        post(sas_pkg::KIND_TICK, 0, 0, 0, 0, 1);
        post(sas_pkg::KIND_SELECT, 0, 0, 0, 4, 0);
        post(sas_pkg::KIND_TICK, 0, 0, 0, 0, 1);
        post(sas_pkg::KIND_RESTART, 0, 0, 0, 0, 0);
        post(sas_pkg::KIND_SELECT, 0, 0, 0, 0, 0);
        post(sas_pkg::KIND_TICK, 0, 0, 0, 0, 2);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin len = 256; frames = 65535; anims = 16; end
                1: begin len = 16;  frames = 64;    anims = 4;  end
                2: begin len = 1;   frames = 1;     anims = 1;  end
                3: begin len = 0;   frames = 0;     anims = 0;  end
                4: begin len = 511; frames = 200;   anims = 31; end
                7: begin len = 64;  frames = 100;   anims = 16; end
                default: begin
                    len    = $urandom_range(2, 256);
                    frames = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                         : $urandom_range(8, 128);
                    anims  = $urandom_range(0, 16);
                end
            endcase
            reconfigure(len, frames, anims);
            idle_pct  = (ph % 4 == 1) ? 78 : (ph % 4 == 3) ? 28 : 0;
            stall_pct = (ph % 4 == 2) ? 78 : (ph % 4 == 3) ? 28 : 0;
            queue_random((ph == 3) ? 15 : 34);
        end

        drain();
        repeat (2 * STEP_BUDGET + 20) @(posedge i_clk);
        if (fault_count == 0 && expected_views.size() == 0) begin
            $display("PASS sprite_animation_sequencer_unit");
        end else begin
            $display("FAIL sprite_animation_sequencer_unit");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL sprite_animation_sequencer_unit");
        $finish;
    end

endmodule

/* files.f */
rtl/sas_pkg.sv
rtl/sas_ram.sv
rtl/sas_useq.sv
rtl/sas_dpath.sv
rtl/sprite_animation_sequencer_unit.sv
bench/testbench.sv
